// ===== design/ucrr_pkg.sv =====
// types and constants shared by the control request resolver modules
package ucrr_pkg;

	// bmRequestType type field
	localparam logic [1:0] TYPE_STANDARD = 2'd0;
	localparam logic [1:0] TYPE_CLASS    = 2'd1;

	// recipients
	localparam logic [4:0] RCP_DEVICE    = 5'd0;
	localparam logic [4:0] RCP_INTERFACE = 5'd1;
	localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

	// standard requests
	localparam logic [7:0] REQ_STATUS_GET  = 8'h00;
	localparam logic [7:0] REQ_FEATURE_CLR = 8'h01;
	localparam logic [7:0] REQ_FEATURE_SET = 8'h03;
	localparam logic [7:0] REQ_ADDRESS_SET = 8'h05;
	localparam logic [7:0] REQ_GET_DESC    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;

	// cdc-acm class requests
	localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
	localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
	localparam logic [7:0] REQ_SET_LINE_STATE  = 8'h22;

	// descriptor types
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;

	// endpoints that exist
	localparam logic [15:0] EP_OUT0 = 16'h0000;
	localparam logic [15:0] EP_OUT1 = 16'h0001;
	localparam logic [15:0] EP_IN1  = 16'h0081;
	localparam logic [15:0] EP_IN2  = 16'h0082;

	localparam logic [15:0] LINE_CODING_BYTES = 16'd7;
	localparam logic [7:0]  ADDR_MAX          = 8'h7f;

	// response kinds
	localparam logic [1:0] KIND_STALL  = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_TX     = 2'd2;
	localparam logic [1:0] KIND_OUT    = 2'd3;

	// data sources
	localparam logic [2:0] SRC_NONE   = 3'd0;
	localparam logic [2:0] SRC_DEVICE = 3'd1;
	localparam logic [2:0] SRC_CONFIG = 3'd2;
	localparam logic [2:0] SRC_STRING = 3'd3;
	localparam logic [2:0] SRC_IMM    = 3'd4;
	localparam logic [2:0] SRC_LINE   = 3'd5;

	localparam logic [7:0] NO_ADDRESS = 8'hff;
	localparam logic [1:0] NO_CONFIG  = 2'b11;

	// configuration register indexes
	localparam logic [1:0] CFG_DEVICE_LEN = 2'd0;
	localparam logic [1:0] CFG_CONFIG_LEN = 2'd1;
	localparam logic [1:0] CFG_PKT_LOG2   = 2'd2;

	localparam logic [2:0] PKT_LOG2_MIN = 3'd3;
	localparam logic [2:0] PKT_LOG2_MAX = 3'd6;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] value_word;
		logic [15:0] index_word;
		logic [15:0] length_word;
		logic        configured;
		logic [7:0]  string_desc_len;
	} setup_t;

	// decoder verdict handed to the length stage
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  src;
		logic [15:0] src_len;
		logic [15:0] imm;
		logic [7:0]  addr;
		logic [1:0]  cfg;
	} verdict_t;

	typedef struct packed {
		logic [1:0]  response_kind;
		logic [2:0]  data_source;
		logic [15:0] data_len;
		logic        zlp_needed;
		logic [15:0] immediate_data;
		logic [7:0]  new_address;
		logic [1:0]  new_config;
	} resp_t;

endpackage

// ===== design/ucrr_decode.sv =====
// request decoder: checks a setup packet and picks the response and data source
module ucrr_decode #(
	parameter int NUM_INTERFACES = 2
) (
	input  ucrr_pkg::setup_t   setup,
	input  logic [7:0]         device_desc_len,
	input  logic [15:0]        config_desc_len,
	output ucrr_pkg::verdict_t verdict
);

	logic        dir_in;
	logic [1:0]  req_kind;
	logic [4:0]  recip;
	logic [7:0]  code;
	logic [15:0] wval;
	logic [15:0] widx;
	logic [15:0] wlen;
	logic        ep_ok;

	assign dir_in   = setup.request_type[7];
	assign req_kind = setup.request_type[6:5];
	assign recip    = setup.request_type[4:0];
	assign code     = setup.request_code;
	assign wval     = setup.value_word;
	assign widx     = setup.index_word;
	assign wlen     = setup.length_word;
	assign ep_ok    = (widx == ucrr_pkg::EP_OUT0) || (widx == ucrr_pkg::EP_OUT1) ||
		(widx == ucrr_pkg::EP_IN1) || (widx == ucrr_pkg::EP_IN2);

	always_comb begin
		verdict.kind     = ucrr_pkg::KIND_STALL;
		verdict.src      = ucrr_pkg::SRC_NONE;
		verdict.src_len  = '0;
		verdict.imm      = '0;
		verdict.addr     = ucrr_pkg::NO_ADDRESS;
		verdict.cfg      = ucrr_pkg::NO_CONFIG;
		if (req_kind == ucrr_pkg::TYPE_STANDARD) begin
			unique case (code) inside
				ucrr_pkg::REQ_GET_DESC: begin
					if (dir_in && recip == ucrr_pkg::RCP_DEVICE) begin
						unique case (wval[15:8])
							ucrr_pkg::DESC_DEVICE: begin
								verdict.kind     = ucrr_pkg::KIND_TX;
								verdict.src      = ucrr_pkg::SRC_DEVICE;
								verdict.src_len  = {8'd0, device_desc_len};
							end
							ucrr_pkg::DESC_CONFIG: begin
								verdict.kind     = ucrr_pkg::KIND_TX;
								verdict.src      = ucrr_pkg::SRC_CONFIG;
								verdict.src_len  = config_desc_len;
							end
							ucrr_pkg::DESC_STRING: begin
								if (setup.string_desc_len != 8'd0) begin
									verdict.kind     = ucrr_pkg::KIND_TX;
									verdict.src      = ucrr_pkg::SRC_STRING;
									verdict.src_len  = {8'd0, setup.string_desc_len};
								end
							end
							default: ;
						endcase
					end
				end
				ucrr_pkg::REQ_ADDRESS_SET: begin
					if (!dir_in && recip == ucrr_pkg::RCP_DEVICE &&
						wval <= {8'd0, ucrr_pkg::ADDR_MAX} && widx == 16'd0 && wlen == 16'd0) begin
						verdict.kind = ucrr_pkg::KIND_STATUS;
						verdict.addr = wval[7:0];
					end
				end
				ucrr_pkg::REQ_SET_CONFIG: begin
					if (!dir_in && recip == ucrr_pkg::RCP_DEVICE && widx == 16'd0 &&
						wlen == 16'd0 && wval <= 16'd1) begin
						verdict.kind = ucrr_pkg::KIND_STATUS;
						verdict.cfg  = {1'b0, wval[0]};
					end
				end
				ucrr_pkg::REQ_GET_CONFIG: begin
					if (dir_in && recip == ucrr_pkg::RCP_DEVICE && wval == 16'd0 &&
						widx == 16'd0 && wlen == 16'd1) begin
						verdict.kind     = ucrr_pkg::KIND_TX;
						verdict.src      = ucrr_pkg::SRC_IMM;
						verdict.src_len  = 16'd1;
						verdict.imm      = {15'd0, setup.configured};
					end
				end
				ucrr_pkg::REQ_STATUS_GET: begin
					if (dir_in && wval == 16'd0 && wlen == 16'd2 &&
						((recip == ucrr_pkg::RCP_DEVICE && widx == 16'd0) ||
						(recip == ucrr_pkg::RCP_INTERFACE && widx < 16'(NUM_INTERFACES)) ||
						(recip == ucrr_pkg::RCP_ENDPOINT && ep_ok))) begin
						verdict.kind     = ucrr_pkg::KIND_TX;
						verdict.src      = ucrr_pkg::SRC_IMM;
						verdict.src_len  = 16'd2;
						// device status reports self powered
						verdict.imm      = (recip == ucrr_pkg::RCP_DEVICE) ? 16'h0001 : 16'h0000;
					end
				end
				ucrr_pkg::REQ_FEATURE_CLR, ucrr_pkg::REQ_FEATURE_SET: begin
					if (!dir_in && wlen == 16'd0 && recip == ucrr_pkg::RCP_ENDPOINT &&
						wval == 16'd0 && ep_ok) begin
						verdict.kind = ucrr_pkg::KIND_STATUS;
					end
				end
				default: ;
			endcase
		end else if (req_kind == ucrr_pkg::TYPE_CLASS) begin
			// class requests only go to the communication interface
			if (recip == ucrr_pkg::RCP_INTERFACE && widx == 16'd0) begin
				unique case (code)
					ucrr_pkg::REQ_GET_LINE_CODING: begin
						if (dir_in && wval == 16'd0 && wlen == ucrr_pkg::LINE_CODING_BYTES) begin
							verdict.kind     = ucrr_pkg::KIND_TX;
							verdict.src      = ucrr_pkg::SRC_LINE;
							verdict.src_len  = ucrr_pkg::LINE_CODING_BYTES;
						end
					end
					ucrr_pkg::REQ_SET_LINE_CODING: begin
						if (!dir_in && wval == 16'd0 && wlen == ucrr_pkg::LINE_CODING_BYTES) begin
							verdict.kind = ucrr_pkg::KIND_OUT;
						end
					end
					ucrr_pkg::REQ_SET_LINE_STATE: begin
						if (!dir_in && wlen == 16'd0) begin
							verdict.kind = ucrr_pkg::KIND_STATUS;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== design/ucrr_send.sv =====
// data stage sizing: caps length to wLength and flags a closing zero-length packet
module ucrr_send (
	input  ucrr_pkg::verdict_t verdict,
	input  logic [15:0]        length_word,
	input  logic [2:0]         ep0_packet_log2,
	output ucrr_pkg::resp_t    resp
);

	logic [2:0]  log2_clamped;
	logic [5:0]  pkt_mask;
	logic [15:0] capped;
	logic        is_tx;

	always_comb begin
		if (ep0_packet_log2 < ucrr_pkg::PKT_LOG2_MIN) begin
			log2_clamped = ucrr_pkg::PKT_LOG2_MIN;
		end else if (ep0_packet_log2 > ucrr_pkg::PKT_LOG2_MAX) begin
			log2_clamped = ucrr_pkg::PKT_LOG2_MAX;
		end else begin
			log2_clamped = ep0_packet_log2;
		end
	end

	// max packet size minus one, at most 63
	assign pkt_mask = 6'(7'((7'd1 << log2_clamped) - 7'd1));
	assign capped   = (verdict.src_len > length_word) ? length_word : verdict.src_len;
	assign is_tx    = (verdict.kind == ucrr_pkg::KIND_TX);

	always_comb begin
		resp.response_kind  = verdict.kind;
		resp.data_source    = is_tx ? verdict.src : ucrr_pkg::SRC_NONE;
		resp.data_len       = is_tx ? capped : 16'd0;
		resp.zlp_needed     = is_tx && capped != 16'd0 && capped < length_word &&
			(capped[5:0] & pkt_mask) == 6'd0;
		resp.immediate_data = (is_tx && verdict.src == ucrr_pkg::SRC_IMM) ? verdict.imm : 16'd0;
		resp.new_address    = verdict.addr;
		resp.new_config     = verdict.cfg;
	end

endmodule

// ===== design/usb_control_request_resolver.sv =====
// Control request resolver: each setup word taken on the slave stream yields one response word
// on the master stream via the input register and then the result register. One word is
// taken every cycle; the single decode and length-capping pass between the two registers sets
// that rate, and a stalled master side fills both registers before s_tready drops. The response
// kind and data source travel in m_tuser, the rest in m_tdata. Configuration writes (device
// descriptor length, configuration set length, log2 of the EP0 packet size) are always ready
// and take effect on the next word decoded; indexes past the last register are ignored.
module usb_control_request_resolver #(
	parameter int NUM_INTERFACES = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// request_type, request_code, value_word, index_word, length_word, configured,
	// string_desc_len, zero pad
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// data_len, zlp_needed, immediate_data, new_address, new_config, zero pad
	output logic [47:0] m_tdata,
	// response_kind, data_source
	output logic [4:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic               valid_s1;
	logic               valid_s2;
	ucrr_pkg::setup_t   setup_s1;
	ucrr_pkg::resp_t    resp_s2;
	ucrr_pkg::verdict_t verdict;
	ucrr_pkg::resp_t    resp;
	logic [7:0]         device_desc_len_q;
	logic [15:0]        config_desc_len_q;
	logic [2:0]         ep0_packet_log2_q;
	logic               ready_s2;
	logic               ready_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_desc_len_q <= 8'd18;
			config_desc_len_q <= 16'd67;
			ep0_packet_log2_q <= 3'd6;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ucrr_pkg::CFG_DEVICE_LEN: device_desc_len_q <= cfg_data[7:0];
				ucrr_pkg::CFG_CONFIG_LEN: config_desc_len_q <= cfg_data;
				ucrr_pkg::CFG_PKT_LOG2:   ep0_packet_log2_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			setup_s1.request_type    <= s_tdata[7:0];
			setup_s1.request_code    <= s_tdata[15:8];
			setup_s1.value_word      <= s_tdata[31:16];
			setup_s1.index_word      <= s_tdata[47:32];
			setup_s1.length_word     <= s_tdata[63:48];
			setup_s1.configured      <= s_tdata[64];
			setup_s1.string_desc_len <= s_tdata[72:65];
		end
		if (ready_s2 && valid_s1) begin
			resp_s2 <= resp;
		end
	end

	ucrr_decode #(
		.NUM_INTERFACES(NUM_INTERFACES)
	) u_decode (
		.setup          (setup_s1),
		.device_desc_len(device_desc_len_q),
		.config_desc_len(config_desc_len_q),
		.verdict        (verdict)
	);

	ucrr_send u_send (
		.verdict        (verdict),
		.length_word    (setup_s1.length_word),
		.ep0_packet_log2(ep0_packet_log2_q),
		.resp           (resp)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = {resp_s2.data_source, resp_s2.response_kind};
	assign m_tdata  = {5'd0, resp_s2.new_config, resp_s2.new_address,
		resp_s2.immediate_data, resp_s2.zlp_needed, resp_s2.data_len};

	// words without a data stage carry no length, no zlp and no source
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && resp_s2.response_kind != ucrr_pkg::KIND_TX |->
		resp_s2.data_len == 16'd0 && !resp_s2.zlp_needed &&
		resp_s2.data_source == ucrr_pkg::SRC_NONE)
		else $error("non-data response carries data stage fields");

	// zlp only after a nonzero, shortened transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && resp_s2.zlp_needed |->
		resp_s2.data_len != 16'd0 && resp_s2.data_len < 16'hffff)
		else $error("zlp flagged on an empty or full-length transfer");

	// an address or configuration change only rides on a status response
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (resp_s2.new_address != ucrr_pkg::NO_ADDRESS ||
		resp_s2.new_config != ucrr_pkg::NO_CONFIG) |->
		resp_s2.response_kind == ucrr_pkg::KIND_STATUS)
		else $error("address or config change outside a status response");

	// input side stalls only when both registers hold a word
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule
